@@ src/cst_pkg.sv @@
// Package with the types, constants and scanner functions of the C source tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LENGTH_BITS = 16;
   localparam int LINE_BITS   = 24;
   localparam int KIND_BITS   = 7;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_BITS = 3;
   localparam int FIFO_CNT_BITS = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;

   localparam logic [KIND_BITS-1:0] K_EOF      = 7'd0;
   localparam logic [KIND_BITS-1:0] K_ERROR    = 7'd1;
   localparam logic [KIND_BITS-1:0] K_IDENT    = 7'd2;
   localparam logic [KIND_BITS-1:0] K_INT      = 7'd3;
   localparam logic [KIND_BITS-1:0] K_FLOAT    = 7'd4;
   localparam logic [KIND_BITS-1:0] K_CHARLIT  = 7'd5;
   localparam logic [KIND_BITS-1:0] K_STRLIT   = 7'd6;
   localparam logic [KIND_BITS-1:0] K_KW0      = 7'd7;
   localparam logic [KIND_BITS-1:0] K_INC      = 7'd39;
   localparam logic [KIND_BITS-1:0] K_DEC      = 7'd40;
   localparam logic [KIND_BITS-1:0] K_ARROW    = 7'd41;
   localparam logic [KIND_BITS-1:0] K_EQ       = 7'd42;
   localparam logic [KIND_BITS-1:0] K_NE       = 7'd43;
   localparam logic [KIND_BITS-1:0] K_LE       = 7'd44;
   localparam logic [KIND_BITS-1:0] K_SHL      = 7'd45;
   localparam logic [KIND_BITS-1:0] K_GE       = 7'd46;
   localparam logic [KIND_BITS-1:0] K_SHR      = 7'd47;
   localparam logic [KIND_BITS-1:0] K_LAND     = 7'd48;
   localparam logic [KIND_BITS-1:0] K_LOR      = 7'd49;
   localparam logic [KIND_BITS-1:0] K_ELLIPSIS = 7'd50;
   localparam logic [KIND_BITS-1:0] K_LPAREN   = 7'd51;
   localparam logic [KIND_BITS-1:0] K_RPAREN   = 7'd52;
   localparam logic [KIND_BITS-1:0] K_LBRACK   = 7'd53;
   localparam logic [KIND_BITS-1:0] K_RBRACK   = 7'd54;
   localparam logic [KIND_BITS-1:0] K_LBRACE   = 7'd55;
   localparam logic [KIND_BITS-1:0] K_RBRACE   = 7'd56;
   localparam logic [KIND_BITS-1:0] K_SEMI     = 7'd57;
   localparam logic [KIND_BITS-1:0] K_COMMA    = 7'd58;
   localparam logic [KIND_BITS-1:0] K_DOT      = 7'd59;
   localparam logic [KIND_BITS-1:0] K_AMP      = 7'd60;
   localparam logic [KIND_BITS-1:0] K_STAR     = 7'd61;
   localparam logic [KIND_BITS-1:0] K_PLUS     = 7'd62;
   localparam logic [KIND_BITS-1:0] K_MINUS    = 7'd63;
   localparam logic [KIND_BITS-1:0] K_TILDE    = 7'd64;
   localparam logic [KIND_BITS-1:0] K_BANG     = 7'd65;
   localparam logic [KIND_BITS-1:0] K_SLASH    = 7'd66;
   localparam logic [KIND_BITS-1:0] K_PERCENT  = 7'd67;
   localparam logic [KIND_BITS-1:0] K_LT       = 7'd68;
   localparam logic [KIND_BITS-1:0] K_GT       = 7'd69;
   localparam logic [KIND_BITS-1:0] K_CARET    = 7'd70;
   localparam logic [KIND_BITS-1:0] K_PIPE     = 7'd71;
   localparam logic [KIND_BITS-1:0] K_QUEST    = 7'd72;
   localparam logic [KIND_BITS-1:0] K_COLON    = 7'd73;
   localparam logic [KIND_BITS-1:0] K_ASSIGN   = 7'd74;

   localparam logic [63:0] KW_TEXT [32] = '{
      64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
      64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
      64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"),
      64'("if"), 64'("int"), 64'("long"), 64'("register"), 64'("return"),
      64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"), 64'("struct"),
      64'("switch"), 64'("typedef"), 64'("union"), 64'("unsigned"), 64'("void"),
      64'("volatile"), 64'("while")};
   localparam logic [3:0] KW_LEN [32] = '{
      4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4,
      4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6,
      4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
      4'd8, 4'd5};

   typedef enum logic [4:0] {
      M_IDLE, M_LINE, M_BLOCK, M_BSTAR, M_SLASH, M_OP, M_DOT1, M_DOT2,
      M_IDENT, M_ZERO, M_OCT, M_DEC, M_HEX, M_SUFFIX, M_NUMDOT, M_FRAC,
      M_EXPS, M_EXPD, M_LIT, M_ESC
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [OFFSET_BITS-1:0] token_start;
      logic [LENGTH_BITS-1:0] token_length;
      logic [LINE_BITS-1:0]   token_line;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      scan_mode_type          mode;
      logic [OFFSET_BITS-1:0] offset;
      logic [LINE_BITS-1:0]   line;
      logic [OFFSET_BITS-1:0] tbegin;
      logic [LENGTH_BITS-1:0] tlen;
      logic [LINE_BITS-1:0]   tline;
      logic [7:0]             look;
      logic [63:0]            word;
      logic                   cr;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      logic          emit;
      rsp_type       tok;
      logic          again;
   } pass_type;

   function automatic tok_state_type reset_state();
      tok_state_type s;
      s = '0;
      s.mode  = M_IDLE;
      s.line  = LINE_BITS'(1);
      s.tline = LINE_BITS'(1);
      return s;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] inc_off(logic [OFFSET_BITS-1:0] v);
      return (v == OFFSET_MAX) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [LENGTH_BITS-1:0] inc_len(logic [LENGTH_BITS-1:0] v);
      return (v == LENGTH_MAX) ? v : v + LENGTH_BITS'(1);
   endfunction

   function automatic logic [LINE_BITS-1:0] inc_line(logic [LINE_BITS-1:0] v);
      return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (c < 8'd128) && (l >= "a") && (l <= "z");
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return is_digit(c) || ((c < 8'd128) && (l >= "a") && (l <= "f"));
   endfunction

   function automatic logic is_isuf(logic [7:0] c);
      return (c == "u") || (c == "U") || (c == "l") || (c == "L");
   endfunction

   function automatic logic is_fsuf(logic [7:0] c);
      return (c == "f") || (c == "F") || (c == "l") || (c == "L");
   endfunction

   function automatic logic [KIND_BITS-1:0] single_kind(logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      unique case (c)
         "(":     k = K_LPAREN;
         ")":     k = K_RPAREN;
         "[":     k = K_LBRACK;
         "]":     k = K_RBRACK;
         "{":     k = K_LBRACE;
         "}":     k = K_RBRACE;
         ";":     k = K_SEMI;
         ",":     k = K_COMMA;
         ".":     k = K_DOT;
         "&":     k = K_AMP;
         "*":     k = K_STAR;
         "+":     k = K_PLUS;
         "-":     k = K_MINUS;
         "~":     k = K_TILDE;
         "!":     k = K_BANG;
         "/":     k = K_SLASH;
         "%":     k = K_PERCENT;
         "<":     k = K_LT;
         ">":     k = K_GT;
         "^":     k = K_CARET;
         "|":     k = K_PIPE;
         "?":     k = K_QUEST;
         ":":     k = K_COLON;
         "=":     k = K_ASSIGN;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_BITS-1:0] pair_kind(logic [7:0] a, logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      unique case ({a, c})
         {"+", "+"}: k = K_INC;
         {"-", "-"}: k = K_DEC;
         {"-", ">"}: k = K_ARROW;
         {"=", "="}: k = K_EQ;
         {"!", "="}: k = K_NE;
         {"<", "="}: k = K_LE;
         {"<", "<"}: k = K_SHL;
         {">", "="}: k = K_GE;
         {">", ">"}: k = K_SHR;
         {"&", "&"}: k = K_LAND;
         {"|", "|"}: k = K_LOR;
         default:    k = K_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_BITS-1:0] ident_kind(tok_state_type s);
      logic [63:0]          v;
      logic [KIND_BITS-1:0] k;
      v = '0;
      k = K_IDENT;
      for (int i = 0; i < 8; i++) begin
         if (LENGTH_BITS'(i) < s.tlen) begin
            v = {v[55:0], s.word[i*8 +: 8]};
         end
      end
      if (s.tlen <= LENGTH_BITS'(8)) begin
         for (int i = 0; i < 32; i++) begin
            if ((v == KW_TEXT[i]) && (s.tlen[3:0] == KW_LEN[i])) begin
               k = K_KW0 + KIND_BITS'(i);
            end
         end
      end
      return k;
   endfunction

   function automatic logic [KIND_BITS-1:0] lit_kind(tok_state_type s);
      return (s.look == "\"") ? K_STRLIT : K_CHARLIT;
   endfunction

   function automatic rsp_type mk_tok(logic [KIND_BITS-1:0] kind,
                                      logic [OFFSET_BITS-1:0] start,
                                      logic [LENGTH_BITS-1:0] len,
                                      logic [LINE_BITS-1:0] line);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.token_line   = line;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   function automatic rsp_type cur_tok(tok_state_type s, logic [KIND_BITS-1:0] kind);
      return mk_tok(kind, s.tbegin, s.tlen, s.tline);
   endfunction

   function automatic pass_type num_other(pass_type p, logic [7:0] c);
      pass_type r;
      r = p;
      if (c == ".") begin
         r.st.mode = M_NUMDOT;
      end else if ((c == "e") || (c == "E")) begin
         r.st.tlen = inc_len(r.st.tlen);
         r.st.mode = M_EXPS;
      end else if (is_isuf(c)) begin
         r.st.tlen = inc_len(r.st.tlen);
         r.st.mode = M_SUFFIX;
      end else begin
         r.emit    = 1'b1;
         r.tok     = cur_tok(p.st, K_INT);
         r.st.mode = M_IDLE;
         r.again   = 1'b1;
      end
      return r;
   endfunction

   function automatic pass_type float_end(pass_type p, logic [7:0] c);
      pass_type r;
      r = p;
      r.emit    = 1'b1;
      r.st.mode = M_IDLE;
      if (is_fsuf(c)) begin
         r.st.tlen = inc_len(r.st.tlen);
      end else begin
         r.again = 1'b1;
      end
      r.tok = cur_tok(r.st, K_FLOAT);
      return r;
   endfunction

   // One scanner step on one byte; a set again flag means the byte is scanned again.
   function automatic pass_type scan_pass(tok_state_type s, logic [7:0] c,
                                          logic [OFFSET_BITS-1:0] pos);
      pass_type r;
      r.st    = s;
      r.emit  = 1'b0;
      r.tok   = '0;
      r.again = 1'b0;
      unique case (s.mode)
         M_IDLE: begin
            priority if ((c == " ") || (c == 8'h09)) begin
            end else if (c == 8'h0A) begin
               r.st.line = inc_line(s.line);
            end else if (c == 8'h0D) begin
               r.st.line = inc_line(s.line);
               r.st.cr   = 1'b1;
            end else if (c == "#") begin
               r.st.mode = M_LINE;
            end else if ((c == "/") || (c == ".") || (c == "+") || (c == "-") ||
                         (c == "=") || (c == "!") || (c == "<") || (c == ">") ||
                         (c == "&") || (c == "|") || (c == "'") || (c == "\"") ||
                         is_alpha(c) || (c == "_") || is_digit(c)) begin
               r.st.tbegin = pos;
               r.st.tlen   = LENGTH_BITS'(1);
               r.st.tline  = s.line;
               r.st.look   = c;
               priority if (c == "/") r.st.mode = M_SLASH;
               else if (c == ".") r.st.mode = M_DOT1;
               else if ((c == "'") || (c == "\"")) r.st.mode = M_LIT;
               else if (is_alpha(c) || (c == "_")) begin
                  r.st.mode      = M_IDENT;
                  r.st.word[7:0] = c;
               end else if (c == "0") r.st.mode = M_ZERO;
               else if (is_digit(c)) r.st.mode = M_DEC;
               else r.st.mode = M_OP;
            end else begin
               r.emit = 1'b1;
               r.tok  = mk_tok(single_kind(c), pos, LENGTH_BITS'(1), s.line);
            end
         end
         M_LINE: begin
            if (c == 8'h0A) begin
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_BLOCK: begin
            if (c == "*") r.st.mode = M_BSTAR;
            else if (c == 8'h0A) r.st.line = inc_line(s.line);
         end
         M_BSTAR: begin
            if (c == "/") r.st.mode = M_IDLE;
            else if (c != "*") begin
               r.st.mode = M_BLOCK;
               if (c == 8'h0A) r.st.line = inc_line(s.line);
            end
         end
         M_SLASH: begin
            if (c == "/") r.st.mode = M_LINE;
            else if (c == "*") r.st.mode = M_BLOCK;
            else begin
               r.emit    = 1'b1;
               r.tok     = cur_tok(s, K_SLASH);
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_OP: begin
            r.emit    = 1'b1;
            r.st.mode = M_IDLE;
            if (pair_kind(s.look, c) != K_ERROR) begin
               r.tok = mk_tok(pair_kind(s.look, c), s.tbegin, LENGTH_BITS'(2), s.tline);
            end else begin
               r.tok   = cur_tok(s, single_kind(s.look));
               r.again = 1'b1;
            end
         end
         M_DOT1: begin
            if (c == ".") begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_DOT2;
            end else begin
               r.emit    = 1'b1;
               r.tok     = mk_tok(K_DOT, s.tbegin, LENGTH_BITS'(1), s.tline);
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_DOT2: begin
            r.emit = 1'b1;
            if (c == ".") begin
               r.tok     = mk_tok(K_ELLIPSIS, s.tbegin, LENGTH_BITS'(3), s.tline);
               r.st.mode = M_IDLE;
            end else begin
               r.tok       = mk_tok(K_DOT, s.tbegin, LENGTH_BITS'(1), s.tline);
               r.st.tbegin = inc_off(s.tbegin);
               r.st.tlen   = LENGTH_BITS'(1);
               r.st.mode   = M_DOT1;
               r.again     = 1'b1;
            end
         end
         M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == "_")) begin
               if (s.tlen < LENGTH_BITS'(8)) r.st.word[{s.tlen[2:0], 3'b000} +: 8] = c;
               r.st.tlen = inc_len(s.tlen);
            end else begin
               r.emit    = 1'b1;
               r.tok     = cur_tok(s, ident_kind(s));
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_ZERO: begin
            if ((c == "x") || (c == "X")) begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_HEX;
            end else if ((c >= "0") && (c <= "7")) begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_OCT;
            end else begin
               r = num_other(r, c);
            end
         end
         M_OCT: begin
            if ((c >= "0") && (c <= "7")) r.st.tlen = inc_len(s.tlen);
            else r = num_other(r, c);
         end
         M_DEC: begin
            if (is_digit(c)) r.st.tlen = inc_len(s.tlen);
            else r = num_other(r, c);
         end
         M_HEX: begin
            if (is_hex(c)) r.st.tlen = inc_len(s.tlen);
            else if (is_isuf(c)) begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_SUFFIX;
            end else begin
               r.emit    = 1'b1;
               r.tok     = cur_tok(s, K_INT);
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_SUFFIX: begin
            if (is_isuf(c)) r.st.tlen = inc_len(s.tlen);
            else begin
               r.emit    = 1'b1;
               r.tok     = cur_tok(s, K_INT);
               r.st.mode = M_IDLE;
               r.again   = 1'b1;
            end
         end
         M_NUMDOT: begin
            if (is_digit(c)) begin
               r.st.tlen = inc_len(inc_len(s.tlen));
               r.st.mode = M_FRAC;
            end else begin
               r.emit      = 1'b1;
               r.tok       = cur_tok(s, K_INT);
               r.st.tbegin = (pos != '0) ? pos - OFFSET_BITS'(1) : '0;
               r.st.tlen   = LENGTH_BITS'(1);
               r.st.mode   = M_DOT1;
               r.again     = 1'b1;
            end
         end
         M_FRAC: begin
            if (is_digit(c)) r.st.tlen = inc_len(s.tlen);
            else if ((c == "e") || (c == "E")) begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_EXPS;
            end else r = float_end(r, c);
         end
         M_EXPS: begin
            if ((c == "+") || (c == "-") || is_digit(c)) begin
               r.st.tlen = inc_len(s.tlen);
               r.st.mode = M_EXPD;
            end else r = float_end(r, c);
         end
         M_EXPD: begin
            if (is_digit(c)) r.st.tlen = inc_len(s.tlen);
            else r = float_end(r, c);
         end
         M_LIT: begin
            r.st.tlen = inc_len(s.tlen);
            if (c == "\\") r.st.mode = M_ESC;
            else if (c == s.look) begin
               r.emit    = 1'b1;
               r.tok     = cur_tok(r.st, lit_kind(s));
               r.st.mode = M_IDLE;
            end
         end
         M_ESC: begin
            r.st.tlen = inc_len(s.tlen);
            r.st.mode = M_LIT;
         end
         default: begin
            r.st.mode = M_IDLE;
            r.again   = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ src/c_source_tokenizer_unit.sv @@
// Top level of the C source tokenizer: scanner state, up to three passes per byte, token queue.
//
//   channel   direction   payload            transfer when
//   req_      in          cst_pkg::req_type  req_valid && req_ready
//   rsp_      out         cst_pkg::rsp_type  rsp_valid && rsp_ready
//
// One source byte is taken per cycle; its tokens (at most three) land in an
// eight-entry queue in the same cycle and leave one per cycle from the next.
// The queue sets the rate: a byte is taken only while three entries are free.
// Reset clears the scanner to its start state and empties the queue.
// A stalled result side fills the queue and then holds the request side.
`timescale 1ns / 1ps
`default_nettype none
module c_source_tokenizer_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cst_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cst_pkg::rsp_type      rsp_data
);
   import cst_pkg::*;

   tok_state_type             state_ff, state_in;
   rsp_type                   fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ff, rd_ff;
   logic [FIFO_CNT_BITS-1:0]  count_ff;

   pass_type                  p1, p2, p3;
   tok_state_type             s0;
   rsp_type                   tok_src [MAX_RESULTS];
   logic [MAX_RESULTS-1:0]    tok_vld;
   rsp_type                   slot [MAX_RESULTS];
   logic [1:0]                n_push;
   logic                      accept, pop;
   logic [7:0]                c;
   logic [OFFSET_BITS-1:0]    pos;

   assign c         = req_data.ch;
   assign pos       = state_ff.offset;
   assign req_ready = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS));
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ff];

   always_comb begin
      s0    = state_ff;
      s0.cr = 1'b0;
      p1 = scan_pass(s0, c, pos);
      p2 = scan_pass(p1.st, c, pos);
      p3 = scan_pass(p2.st, c, pos);
      tok_src[0] = '0;
      tok_src[1] = '0;
      tok_src[2] = '0;
      tok_vld    = '0;
      state_in   = state_ff;
      if (req_data.end_of_source) begin
         state_in = reset_state();
         unique case (state_ff.mode)
            M_SLASH: begin
               tok_src[0] = cur_tok(state_ff, K_SLASH);
               tok_vld[0] = 1'b1;
            end
            M_OP: begin
               tok_src[0] = cur_tok(state_ff, single_kind(state_ff.look));
               tok_vld[0] = 1'b1;
            end
            M_DOT1: begin
               tok_src[0] = mk_tok(K_DOT, state_ff.tbegin, LENGTH_BITS'(1), state_ff.tline);
               tok_vld[0] = 1'b1;
            end
            M_DOT2: begin
               tok_src[0] = mk_tok(K_DOT, state_ff.tbegin, LENGTH_BITS'(1), state_ff.tline);
               tok_src[1] = mk_tok(K_DOT, inc_off(state_ff.tbegin), LENGTH_BITS'(1),
                                   state_ff.tline);
               tok_vld[1:0] = 2'b11;
            end
            M_IDENT: begin
               tok_src[0] = cur_tok(state_ff, ident_kind(state_ff));
               tok_vld[0] = 1'b1;
            end
            M_ZERO, M_OCT, M_DEC, M_HEX, M_SUFFIX: begin
               tok_src[0] = cur_tok(state_ff, K_INT);
               tok_vld[0] = 1'b1;
            end
            M_NUMDOT: begin
               tok_src[0] = cur_tok(state_ff, K_INT);
               tok_src[1] = mk_tok(K_DOT,
                                   (pos != '0) ? pos - OFFSET_BITS'(1) : '0,
                                   LENGTH_BITS'(1), state_ff.tline);
               tok_vld[1:0] = 2'b11;
            end
            M_FRAC, M_EXPS, M_EXPD: begin
               tok_src[0] = cur_tok(state_ff, K_FLOAT);
               tok_vld[0] = 1'b1;
            end
            M_LIT, M_ESC: begin
               tok_src[0] = cur_tok(state_ff, lit_kind(state_ff));
               tok_vld[0] = 1'b1;
            end
            default: begin
            end
         endcase
         tok_src[2] = mk_tok(K_EOF, pos, '0, state_ff.line);
         tok_vld[2] = 1'b1;
      end else if (state_ff.cr && (c == 8'h0A)) begin
         state_in.cr     = 1'b0;
         state_in.offset = inc_off(pos);
      end else begin
         tok_src[0] = p1.tok;
         tok_src[1] = p2.tok;
         tok_src[2] = p3.tok;
         tok_vld[0] = p1.emit;
         tok_vld[1] = p1.again && p2.emit;
         tok_vld[2] = p1.again && p2.again && p3.emit;
         state_in   = !p1.again ? p1.st : (!p2.again ? p2.st : p3.st);
         state_in.offset = inc_off(pos);
      end
   end

   always_comb begin
      slot[0] = '0;
      slot[1] = '0;
      slot[2] = '0;
      n_push  = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (tok_vld[i]) begin
            slot[n_push] = tok_src[i];
            n_push       = n_push + 2'd1;
         end
      end
      if (n_push != '0) begin
         slot[n_push - 2'd1].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reset_state();
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            wr_ff    <= wr_ff + FIFO_PTR_BITS'(n_push);
         end
         if (pop) begin
            rd_ff <= rd_ff + FIFO_PTR_BITS'(1);
         end
         count_ff <= count_ff + (accept ? FIFO_CNT_BITS'(n_push) : '0)
                     - (pop ? FIFO_CNT_BITS'(1) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (FIFO_CNT_BITS'(k) < FIFO_CNT_BITS'(n_push)) begin
               fifo_ff[wr_ff + FIFO_PTR_BITS'(k)] <= slot[k];
            end
         end
      end
   end

endmodule
`default_nettype wire

@@ tb/tb_c_source_tokenizer_unit.sv @@
// Testbench for the C source tokenizer: directed and random source text, checked token by token.
`timescale 1ns / 1ps
`default_nettype none
module tb_c_source_tokenizer_unit;
   import cst_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int TOTAL_ITEMS = 310;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   c_source_tokenizer_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Scanner copy used to work out the expected tokens.
   scan_mode_type          mode;
   logic [OFFSET_BITS-1:0] src_offset;
   logic [LINE_BITS-1:0]   src_line;
   logic [OFFSET_BITS-1:0] tok_start;
   logic [LENGTH_BITS-1:0] tok_len;
   logic [LINE_BITS-1:0]   tok_line;
   logic [7:0]             open_ch;
   logic [7:0]             word [8];
   logic                   cr_pending;

   rsp_type step_tokens [$];
   rsp_type expected_tokens [$];
   int      error_count = 0;
   int      items_sent = 0;
   bit      quiet = 1'b0;
   int      idle_cycles = 0;

   string keyword_names [32] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"};
   string single_chars = "()[]{};,.&*+-~!/%<>^|?:=";

   string fragments [] = '{
      "int", "while", "volatile", "sizeof", "typedef", "unsigned", "continue",
      "register", "x_1", "volatilex", "_", "abcdefghij", "0x1fUL", "0X", "0xg",
      "017", "089", "0", "123lu", "1.5e+3f", "2.", "3..", "4.e", "7e-2L", "1.5ff",
      "'a'", "'\\''", "\"ab\\\"c\"", "\"x\ny\"", "/* a\n*b**/", "// c\n",
      "#define x\n", "...", "..", ".", "->", "++", "--", "==", "!=", "<=", "<<",
      ">=", ">>", "&&", "||", "+=", "/", "a/b", "\r\n", "\r", "\n", " ", "\t",
      "(", ")", "[", "]", "{", "}", ";", ",", "~", "%", "^", "?", ":", "*", "@", "$"};

   function automatic bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_char(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return c < 8'd128 && l >= "a" && l <= "z";
   endfunction

   function automatic bit int_suffix(logic [7:0] c);
      return c == "u" || c == "U" || c == "l" || c == "L";
   endfunction

   function automatic bit float_suffix(logic [7:0] c);
      return c == "f" || c == "F" || c == "l" || c == "L";
   endfunction

   function automatic logic [KIND_BITS-1:0] punct_kind(logic [7:0] c);
      for (int i = 0; i < 24; i++) begin
         if (single_chars.getc(i) == c) return K_LPAREN + KIND_BITS'(i);
      end
      return K_ERROR;
   endfunction

   function automatic logic [KIND_BITS-1:0] pair_token_kind(logic [7:0] a, logic [7:0] c);
      case ({a, c})
         {"+", "+"}: return K_INC;
         {"-", "-"}: return K_DEC;
         {"-", ">"}: return K_ARROW;
         {"=", "="}: return K_EQ;
         {"!", "="}: return K_NE;
         {"<", "="}: return K_LE;
         {"<", "<"}: return K_SHL;
         {">", "="}: return K_GE;
         {">", ">"}: return K_SHR;
         {"&", "&"}: return K_LAND;
         {"|", "|"}: return K_LOR;
         default:    return K_ERROR;
      endcase
   endfunction

   function automatic logic [KIND_BITS-1:0] word_kind();
      bit same;
      if (tok_len > 8) return K_IDENT;
      for (int i = 0; i < 32; i++) begin
         same = keyword_names[i].len() == int'(tok_len);
         for (int j = 0; j < 8; j++) begin
            if (same && j < int'(tok_len) && keyword_names[i].getc(j) != word[j]) same = 1'b0;
         end
         if (same) return K_KW0 + KIND_BITS'(i);
      end
      return K_IDENT;
   endfunction

   function automatic logic [KIND_BITS-1:0] quote_kind();
      return open_ch == "\"" ? K_STRLIT : K_CHARLIT;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] next_offset(logic [OFFSET_BITS-1:0] v);
      return v == '1 ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] next_line(logic [LINE_BITS-1:0] v);
      return v == '1 ? v : v + 1'b1;
   endfunction

   function automatic void grow();
      if (tok_len != '1) tok_len = tok_len + 1'b1;
   endfunction

   function automatic void add_token(logic [KIND_BITS-1:0] kind, logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len, logic [LINE_BITS-1:0] line);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.token_line   = line;
      t.last_of_run  = 1'b0;
      if (step_tokens.size() < MAX_RESULTS) step_tokens.push_back(t);
   endfunction

   function automatic void add_current(logic [KIND_BITS-1:0] kind);
      add_token(kind, tok_start, tok_len, tok_line);
   endfunction

   function automatic void start_token(logic [OFFSET_BITS-1:0] pos, scan_mode_type m);
      tok_start = pos;
      tok_len   = 1;
      tok_line  = src_line;
      mode      = m;
   endfunction

   function automatic void clear_scanner();
      mode       = M_IDLE;
      src_offset = '0;
      src_line   = 1;
      tok_start  = '0;
      tok_len    = '0;
      tok_line   = 1;
      cr_pending = 1'b0;
   endfunction

   function automatic bit number_break(logic [7:0] c);
      if (c == ".") begin
         mode = M_NUMDOT;
         return 1'b0;
      end
      if (c == "e" || c == "E") begin
         grow();
         mode = M_EXPS;
         return 1'b0;
      end
      if (int_suffix(c)) begin
         grow();
         mode = M_SUFFIX;
         return 1'b0;
      end
      add_current(K_INT);
      mode = M_IDLE;
      return 1'b1;
   endfunction

   function automatic bit float_done(logic [7:0] c);
      bit rescan;
      rescan = !float_suffix(c);
      if (!rescan) grow();
      add_current(K_FLOAT);
      mode = M_IDLE;
      return rescan;
   endfunction

   function automatic void scan_byte(logic [7:0] c, logic [OFFSET_BITS-1:0] pos);
      bit again;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (mode)
            M_IDLE: begin
               if (c == " " || c == 8'h09) begin
               end else if (c == 8'h0A) begin
                  src_line = next_line(src_line);
               end else if (c == 8'h0D) begin
                  src_line = next_line(src_line);
                  cr_pending = 1'b1;
               end else if (c == "/") begin
                  start_token(pos, M_SLASH);
               end else if (c == "#") begin
                  mode = M_LINE;
               end else if (c == ".") begin
                  start_token(pos, M_DOT1);
               end else if (c == "+" || c == "-" || c == "=" || c == "!" || c == "<" ||
                            c == ">" || c == "&" || c == "|") begin
                  open_ch = c;
                  start_token(pos, M_OP);
               end else if (c == "'" || c == "\"") begin
                  open_ch = c;
                  start_token(pos, M_LIT);
               end else if (punct_kind(c) != K_ERROR) begin
                  add_token(punct_kind(c), pos, 1, src_line);
               end else if (alpha_char(c) || c == "_") begin
                  start_token(pos, M_IDENT);
                  word[0] = c;
               end else if (c == "0") begin
                  start_token(pos, M_ZERO);
               end else if (digit_char(c)) begin
                  start_token(pos, M_DEC);
               end else begin
                  add_token(K_ERROR, pos, 1, src_line);
               end
            end
            M_LINE: begin
               if (c == 8'h0A) begin
                  mode = M_IDLE;
                  again = 1'b1;
               end
            end
            M_BLOCK: begin
               if (c == "*") mode = M_BSTAR;
               else if (c == 8'h0A) src_line = next_line(src_line);
            end
            M_BSTAR: begin
               if (c == "/") begin
                  mode = M_IDLE;
               end else if (c != "*") begin
                  mode = M_BLOCK;
                  if (c == 8'h0A) src_line = next_line(src_line);
               end
            end
            M_SLASH: begin
               if (c == "/") begin
                  mode = M_LINE;
               end else if (c == "*") begin
                  mode = M_BLOCK;
               end else begin
                  add_current(K_SLASH);
                  mode = M_IDLE;
                  again = 1'b1;
               end
            end
            M_OP: begin
               mode = M_IDLE;
               if (pair_token_kind(open_ch, c) != K_ERROR) begin
                  add_token(pair_token_kind(open_ch, c), tok_start, 2, tok_line);
               end else begin
                  add_current(punct_kind(open_ch));
                  again = 1'b1;
               end
            end
            M_DOT1: begin
               if (c == ".") begin
                  grow();
                  mode = M_DOT2;
               end else begin
                  add_token(K_DOT, tok_start, 1, tok_line);
                  mode = M_IDLE;
                  again = 1'b1;
               end
            end
            M_DOT2: begin
               if (c == ".") begin
                  add_token(K_ELLIPSIS, tok_start, 3, tok_line);
                  mode = M_IDLE;
               end else begin
                  add_token(K_DOT, tok_start, 1, tok_line);
                  tok_start = next_offset(tok_start);
                  tok_len = 1;
                  mode = M_DOT1;
                  again = 1'b1;
               end
            end
            M_IDENT: begin
               if (alpha_char(c) || digit_char(c) || c == "_") begin
                  if (tok_len < 8) word[tok_len[2:0]] = c;
                  grow();
               end else begin
                  add_current(word_kind());
                  mode = M_IDLE;
                  again = 1'b1;
               end
            end
            M_ZERO: begin
               if (c == "x" || c == "X") begin
                  grow();
                  mode = M_HEX;
               end else if (c >= "0" && c <= "7") begin
                  grow();
                  mode = M_OCT;
               end else begin
                  again = number_break(c);
               end
            end
            M_OCT: begin
               if (c >= "0" && c <= "7") grow();
               else again = number_break(c);
            end
            M_DEC: begin
               if (digit_char(c)) grow();
               else again = number_break(c);
            end
            M_HEX, M_SUFFIX: begin
               if (mode == M_HEX && (digit_char(c) ||
                   (c < 8'd128 && (c | 8'h20) >= "a" && (c | 8'h20) <= "f"))) begin
                  grow();
               end else if (int_suffix(c)) begin
                  grow();
                  mode = M_SUFFIX;
               end else begin
                  add_current(K_INT);
                  mode = M_IDLE;
                  again = 1'b1;
               end
            end
            M_NUMDOT: begin
               if (digit_char(c)) begin
                  grow();
                  grow();
                  mode = M_FRAC;
               end else begin
                  add_current(K_INT);
                  tok_start = pos != '0 ? pos - 1'b1 : '0;
                  tok_len = 1;
                  mode = M_DOT1;
                  again = 1'b1;
               end
            end
            M_FRAC: begin
               if (digit_char(c)) begin
                  grow();
               end else if (c == "e" || c == "E") begin
                  grow();
                  mode = M_EXPS;
               end else begin
                  again = float_done(c);
               end
            end
            M_EXPS: begin
               if (c == "+" || c == "-" || digit_char(c)) begin
                  grow();
                  mode = M_EXPD;
               end else begin
                  again = float_done(c);
               end
            end
            M_EXPD: begin
               if (digit_char(c)) grow();
               else again = float_done(c);
            end
            M_LIT: begin
               grow();
               if (c == "\\") begin
                  mode = M_ESC;
               end else if (c == open_ch) begin
                  add_current(quote_kind());
                  mode = M_IDLE;
               end
            end
            M_ESC: begin
               grow();
               mode = M_LIT;
            end
            default: begin
               mode = M_IDLE;
               again = 1'b1;
            end
         endcase
      end
   endfunction

   function automatic void flush_source();
      case (mode)
         M_SLASH: add_current(K_SLASH);
         M_OP: add_current(punct_kind(open_ch));
         M_DOT1: add_token(K_DOT, tok_start, 1, tok_line);
         M_DOT2: begin
            add_token(K_DOT, tok_start, 1, tok_line);
            add_token(K_DOT, next_offset(tok_start), 1, tok_line);
         end
         M_IDENT: add_current(word_kind());
         M_ZERO, M_OCT, M_DEC, M_HEX, M_SUFFIX: add_current(K_INT);
         M_NUMDOT: begin
            add_current(K_INT);
            add_token(K_DOT, src_offset != '0 ? src_offset - 1'b1 : '0, 1, tok_line);
         end
         M_FRAC, M_EXPS, M_EXPD: add_current(K_FLOAT);
         M_LIT, M_ESC: add_current(quote_kind());
         default: ;
      endcase
      add_token(K_EOF, src_offset, 0, src_line);
   endfunction

   function automatic void predict_tokens(req_type item);
      logic [OFFSET_BITS-1:0] pos;
      pos = src_offset;
      step_tokens.delete();
      if (item.end_of_source) begin
         flush_source();
         clear_scanner();
      end else if (cr_pending && item.ch == 8'h0A) begin
         cr_pending = 1'b0;
         src_offset = next_offset(pos);
      end else begin
         cr_pending = 1'b0;
         scan_byte(item.ch, pos);
         src_offset = next_offset(pos);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   task automatic send_item(input logic [7:0] ch, input logic eos);
      req_type item;
      item.ch = ch;
      item.end_of_source = eos;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tokens(item);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s.getc(i), 1'b0);
   endtask

   task automatic test_operators();
      send_text("a+=b->c...d..e.f<<=g>>h&&i||j!=k==l--m++n<o>p/q");
      send_text("()[]{};,~%^?:*");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'hAA, 1'b1);
   endtask

   task automatic test_numbers_and_words();
      send_text("0x 0x1fUL 017 089 12lu 1.5e+3f 2.x 3.. 4.e 7e-2Lf 1.5ff ");
      send_text("auto while volatile volatilex sizeof typedef _x9 ");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_literals_and_comments();
      send_text("'\\'' \"a\\\"b\nc\" /* x\n**/ // y\r\n#z\n\r\r\n\t q");
      send_item(8'h00, 1'b1);
      send_text("/* open\n");
      send_item(8'h00, 1'b1);
      send_text("\"open");
      send_item(8'h00, 1'b1);
      send_text("9.");
      send_item(8'h00, 1'b1);
      send_text("..");
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_source();
      int pick;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent > TOTAL_ITEMS - 60) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 70) send_text(fragments[$urandom_range(0, fragments.size() - 1)]);
         else if (pick < 90) send_item(8'($urandom_range(0, 255)), 1'b0);
         else if (pick < 97) send_item(" ", 1'b0);
         else send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      send_item(8'h00, 1'b1);
   endtask

   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected token transfer: kind %0d", rsp_data.token_kind);
            error_count++;
         end else begin
            if (rsp_data.token_kind !== expected_tokens[0].token_kind) begin
               $error("token_kind: expected %0d, got %0d",
                      expected_tokens[0].token_kind, rsp_data.token_kind);
               error_count++;
            end
            if (rsp_data.token_start !== expected_tokens[0].token_start) begin
               $error("token_start: expected %0d, got %0d",
                      expected_tokens[0].token_start, rsp_data.token_start);
               error_count++;
            end
            if (rsp_data.token_length !== expected_tokens[0].token_length) begin
               $error("token_length: expected %0d, got %0d",
                      expected_tokens[0].token_length, rsp_data.token_length);
               error_count++;
            end
            if (rsp_data.token_line !== expected_tokens[0].token_line) begin
               $error("token_line: expected %0d, got %0d",
                      expected_tokens[0].token_line, rsp_data.token_line);
               error_count++;
            end
            if (rsp_data.last_of_run !== expected_tokens[0].last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      expected_tokens[0].last_of_run, rsp_data.last_of_run);
               error_count++;
            end
            void'(expected_tokens.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clear_scanner();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operators();
      test_numbers_and_words();
      test_literals_and_comments();
      test_random_source();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
